/* src/station_address_learning_table_top_assert.svh */
// Assertion macros for the station address learning table.
// Included by the top level for its concurrent checks; no other dependencies.
`ifndef STATION_ADDRESS_LEARNING_TABLE_TOP_ASSERT_SVH
`define STATION_ADDRESS_LEARNING_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SLAT_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
`define SLAT_CHECK_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define SLAT_CHECK(lbl, clk, rst_n, prop, msg)
`define SLAT_CHECK_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/slat_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the entry update rule of the learning table.
// No dependencies; imported by slat_cell and the top level.
package slat_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic       ACT_FRAME      = 1'b0;
	localparam logic       ACT_READ       = 1'b1;
	localparam logic [1:0] TYPE_MGMT      = 2'd0;
	localparam logic [3:0] SUB_BEACON     = 4'd8;
	localparam logic [3:0] SUB_PROBE_RESP = 4'd5;

	localparam logic [2:0] ST_IGNORED  = 3'd0;
	localparam logic [2:0] ST_UPDATED  = 3'd1;
	localparam logic [2:0] ST_ADMITTED = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_READ_OK  = 3'd4;
	localparam logic [2:0] ST_READ_BAD = 3'd5;

	localparam logic [31:0] FRAMES_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic              action;
		logic [1:0]        frame_type;
		logic [3:0]        frame_subtype;
		logic [47:0]       station_address;
		logic signed [7:0] signal_strength;
		logic [7:0]        radio_channel;
		logic              protected_flag;
		logic              mgmt_protect_seen;
		logic [5:0]        read_index;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [5:0]        entry_index;
		logic [6:0]        entries_in_use;
		logic [47:0]       entry_address;
		logic [31:0]       entry_frames;
		logic signed [7:0] entry_signal;
		logic [7:0]        entry_channel;
		logic              entry_privacy;
		logic              entry_mfp;
	} rsp_t;

	typedef struct packed {
		logic [47:0]       address;
		logic [31:0]       frames;
		logic signed [7:0] signal;
		logic [7:0]        channel;
		logic              privacy;
		logic              mfp;
	} entry_t;

	// Control from the sequencer to every cell in the row.
	typedef struct packed {
		logic lookup;
		logic read_op;
		logic commit;
		logic alloc;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	function automatic entry_t entry_update(entry_t old, logic hit, req_t r);
		entry_t e;
		e.address = r.station_address;
		if (!hit) begin
			e.frames = 32'd1;
		end else if (old.frames == FRAMES_MAX) begin
			e.frames = old.frames;
		end else begin
			e.frames = old.frames + 32'd1;
		end
		e.signal  = r.signal_strength;
		e.channel = r.radio_channel;
		e.privacy = r.protected_flag;
		e.mfp     = (hit & old.mfp) | r.mgmt_protect_seen;
		return e;
	endfunction

endpackage

/* src/station_address_learning_table_top.sv */
`timescale 1ns / 1ps
// Top level of the station address learning table: sequencer, row of cells,
// result register. Depends on slat_pkg, slat_cell and the assertion header.
//
//  port group   dir  handshake             payload
//  request      in   req_valid/req_ready   req (slat_pkg::req_t)
//  response     out  rsp_valid/rsp_ready   rsp (slat_pkg::rsp_t)
//
// Each request is captured while idle; in the work state every cell
// compares its address in parallel, the hit or new slot is written and the
// response register loads. A stalled response holds the sequencer in its work
// state; the next request is taken once the response register is loaded.
// Reset clears state, rsp_valid and entry count; no clearing pass is needed.
`include "station_address_learning_table_top_assert.svh"
module station_address_learning_table_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  slat_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output slat_pkg::rsp_t   rsp
);
	import slat_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	req_t                   req_s1;
	rsp_t                   rsp_q;
	rsp_t                   rsp_d;
	logic                   rsp_valid_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_load;
	logic                   kept;
	logic                   hit;
	logic                   full;
	logic                   read_ok;
	logic [IDX_W-1:0]       slot;
	logic [MAX_ENTRIES-1:0] match_vec;
	entry_t                 cell_rd [MAX_ENTRIES];
	entry_t                 gathered;
	entry_t                 new_entry;
	logic                   do_lookup;
	logic                   do_read;
	logic                   do_alloc;
	logic                   do_commit;
	cell_ctl_t              ctl;

	assign kept = (req_s1.frame_type == TYPE_MGMT) &&
		((req_s1.frame_subtype == SUB_BEACON) || (req_s1.frame_subtype == SUB_PROBE_RESP));
	assign full    = (count_q == CNT_W'(MAX_ENTRIES));
	assign read_ok = 32'(req_s1.read_index) < 32'(count_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_WORK;
			end
			ST_WORK: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		out_load  = 1'b0;
		do_lookup = 1'b0;
		do_read   = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_WORK: begin
				out_load  = !rsp_valid_q || rsp_ready;
				do_lookup = (req_s1.action == ACT_FRAME) && kept;
				do_read   = (req_s1.action == ACT_READ);
			end
			default: ;
		endcase
	end

	assign hit       = do_lookup && (|match_vec);
	assign do_alloc  = do_lookup && !hit && !full;
	assign do_commit = out_load && do_lookup && (hit || !full);
	assign ctl       = '{lookup: do_lookup, read_op: do_read, commit: do_commit, alloc: do_alloc};

	genvar g;
	generate
		for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
			slat_cell u_cell (
				.clk      (clk),
				.idx      (IDX_W'(g)),
				.count    (count_q),
				.req      (req_s1),
				.ctl      (ctl),
				.match    (match_vec[g]),
				.rd_entry (cell_rd[g])
			);
		end
	endgenerate

	// At most one cell drives a nonzero entry; merge and encode the hit slot.
	always_comb begin
		gathered = '0;
		slot     = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			gathered = gathered | cell_rd[i];
			if (match_vec[i]) slot = slot | IDX_W'(i);
		end
	end

	assign new_entry = entry_update(gathered, hit, req_s1);

	always_comb begin
		rsp_d                = '0;
		rsp_d.entries_in_use = 7'(count_q);
		if (req_s1.action == ACT_READ) begin
			rsp_d.entry_index = req_s1.read_index;
			rsp_d.status      = read_ok ? ST_READ_OK : ST_READ_BAD;
			if (read_ok) begin
				rsp_d.entry_address = gathered.address;
				rsp_d.entry_frames  = gathered.frames;
				rsp_d.entry_signal  = gathered.signal;
				rsp_d.entry_channel = gathered.channel;
				rsp_d.entry_privacy = gathered.privacy;
				rsp_d.entry_mfp     = gathered.mfp;
			end
		end else if (!kept) begin
			rsp_d.status = ST_IGNORED;
		end else if (!hit && full) begin
			rsp_d.status = ST_FULL;
		end else begin
			rsp_d.status        = hit ? ST_UPDATED : ST_ADMITTED;
			rsp_d.entry_index   = hit ? 6'(slot) : 6'(count_q);
			rsp_d.entries_in_use = hit ? 7'(count_q) : 7'(count_q + CNT_W'(1));
			rsp_d.entry_address = new_entry.address;
			rsp_d.entry_frames  = new_entry.frames;
			rsp_d.entry_signal  = new_entry.signal;
			rsp_d.entry_channel = new_entry.channel;
			rsp_d.entry_privacy = new_entry.privacy;
			rsp_d.entry_mfp     = new_entry.mfp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_commit && do_alloc) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SLAT_CHECK(a_count_cap, clk, arst_n, count_q <= CNT_W'(MAX_ENTRIES), "entry count above table size")
	`SLAT_CHECK(a_match_unique, clk, arst_n, $onehot0(match_vec), "address matched in more than one slot")
	`SLAT_CHECK_IMP(a_count_step, clk, arst_n, count_q != $past(count_q), count_q == $past(count_q) + CNT_W'(1), "entry count moved by other than one")
	`SLAT_CHECK_IMP(a_rsp_from_work, clk, arst_n, $rose(rsp_valid_q), $past(state_q == ST_WORK), "response raised outside work state")

endmodule

/* src/slat_cell.sv */
`timescale 1ns / 1ps
// One slot of the learning table: stores an entry, matches the broadcast
// address and updates itself on commit. Depends on slat_pkg.
module slat_cell (
	input  logic                     clk,
	input  logic [slat_pkg::IDX_W-1:0] idx,
	input  logic [slat_pkg::CNT_W-1:0] count,
	input  slat_pkg::req_t           req,
	input  slat_pkg::cell_ctl_t      ctl,
	output logic                     match,
	output slat_pkg::entry_t         rd_entry
);
	import slat_pkg::*;

	entry_t entry_q;
	logic   live;
	logic   rd_sel;
	logic   alloc_sel;
	logic   we;

	assign live      = 32'(idx) < 32'(count);
	assign match     = live && (entry_q.address == req.station_address);
	assign rd_sel    = ctl.read_op && (32'(idx) == 32'(req.read_index));
	assign alloc_sel = ctl.alloc && (32'(idx) == 32'(count));
	assign we        = ctl.commit && (match || alloc_sel);

	// Drive zero when not selected so the row can be OR-merged.
	assign rd_entry = ((ctl.lookup && match) || rd_sel) ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= entry_update(entry_q, match, req);
		end
	end

endmodule
